/* hw/rtl/i2c_mrt_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master register transfer: shared package
// Types, command and phase codes, and the address byte picker.
// ----------------------------------------------------------------------------
package i2c_mrt_pkg;

  // transaction phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ADDR   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_FINISH = 2'd3;

  // controller commands
  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_SEND_START  = 3'd1;
  localparam logic [2:0] CMD_SEND_CONT   = 3'd2;
  localparam logic [2:0] CMD_SEND_FINISH = 3'd3;
  localparam logic [2:0] CMD_SINGLE_RECV = 3'd4;
  localparam logic [2:0] CMD_RECV_START  = 3'd5;
  localparam logic [2:0] CMD_RECV_CONT   = 3'd6;
  localparam logic [2:0] CMD_RECV_FINISH = 3'd7;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;

  // one input item
  typedef struct packed {
    logic        req_type;
    logic [6:0]  slave_addr;
    logic [31:0] mem_addr;
    logic [3:0]  addr_len;
    logic [15:0] data_size;
    logic        is_read;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic        int_pending;
    logic [1:0]  ctrl_error;
  } req_t;

  // sequencer state apart from the data position
  typedef struct packed {
    logic [1:0]  phase;
    logic        read_mode;
    logic [6:0]  slave_hold;
    logic [31:0] address_hold;
    logic [2:0]  address_count;
    logic [2:0]  address_pos;
    logic [15:0] size_hold;
  } state_t;

  // result fields apart from the buffer indices
  typedef struct packed {
    logic [2:0] command;
    logic       slave_set;
    logic       slave_read;
    logic [6:0] slave_out;
    logic       put_valid;
    logic [7:0] put_byte;
    logic       store_valid;
    logic [7:0] store_byte;
    logic       done_res;
    logic [1:0] result_error;
  } ctl_t;

  // address byte k of cnt, most significant first
  function automatic logic [7:0] addr_byte(logic [31:0] addr, logic [2:0] cnt,
                                           logic [2:0] k);
    logic [2:0] d;
    logic [7:0] b;
    d = cnt - 3'd1 - k;
    case (d[1:0])
      2'd0:    b = addr[7:0];
      2'd1:    b = addr[15:8];
      2'd2:    b = addr[23:16];
      default: b = addr[31:24];
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/i2c_mrt_if.sv */
// ----------------------------------------------------------------------------
// I2C master register transfer: channel interfaces
// Request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2c_mrt_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [6:0]  slave_addr;
  logic [31:0] mem_addr;
  logic [3:0]  addr_len;
  logic [15:0] data_size;
  logic        is_read;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  logic        int_pending;
  logic [1:0]  ctrl_error;

  modport source (output valid, req_type, slave_addr, mem_addr, addr_len, data_size,
                  is_read, tx_byte, rx_byte, int_pending, ctrl_error,
                  input ready);
  modport sink (input valid, req_type, slave_addr, mem_addr, addr_len, data_size,
                is_read, tx_byte, rx_byte, int_pending, ctrl_error,
                output ready);
endinterface

interface i2c_mrt_res_if #(parameter int INDEX_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [2:0]            command;
  logic                  slave_set;
  logic                  slave_read;
  logic [6:0]            slave_out;
  logic                  put_valid;
  logic [7:0]            put_byte;
  logic                  store_valid;
  logic [INDEX_BITS-1:0] store_index;
  logic [7:0]            store_byte;
  logic [INDEX_BITS-1:0] next_index;
  logic                  done_res;
  logic [1:0]            result_error;

  modport source (output valid, command, slave_set, slave_read, slave_out, put_valid,
                  put_byte, store_valid, store_index, store_byte, next_index,
                  done_res, result_error,
                  input ready);
  modport sink (input valid, command, slave_set, slave_read, slave_out, put_valid,
                put_byte, store_valid, store_index, store_byte, next_index,
                done_res, result_error,
                output ready);
endinterface

/* hw/rtl/i2c_master_register_transfer.sv */
// ----------------------------------------------------------------------------
// I2C master register transfer
// Sequences one I2C master register read or write transaction, at most one
// controller command per event.
// ----------------------------------------------------------------------------
//  Channel | Dir | Carries
//  req     | in  | start request or controller event
//  res     | out | command, slave load, put byte, stored byte, done/error
//
// One item per cycle sustained while res is ready; each item is held in the input
// register, then passes through the step logic into the result register on res.
// A stalled res holds its result; the input register still takes one item.
// rst clears the phase, the holding state and both valid flags.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer
  import i2c_mrt_pkg::*;
#(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int INDEX_BITS     = 16
) (
  input  logic       clk,
  input  logic       rst,
  i2c_mrt_req_if.sink   req,
  i2c_mrt_res_if.source res
);

  req_t                  req_q;
  logic                  req_vld;
  logic                  adv;

  state_t                st;
  state_t                st_next;
  logic [INDEX_BITS-1:0] data_pos;
  logic [INDEX_BITS-1:0] data_pos_next;

  ctl_t                  ctl_next;
  logic [INDEX_BITS-1:0] store_index_next;
  logic [INDEX_BITS-1:0] next_index_next;

  ctl_t                  ctl;
  logic [INDEX_BITS-1:0] store_index;
  logic [INDEX_BITS-1:0] next_index;
  logic                  res_vld;

  // handshake: step when the result register is free or being drained
  assign adv       = req_vld && (!res_vld || res.ready);
  assign req.ready = !req_vld || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (req.ready) begin
      req_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q <= '{req_type:    req.req_type,
                 slave_addr:  req.slave_addr,
                 mem_addr:    req.mem_addr,
                 addr_len:    req.addr_len,
                 data_size:   req.data_size,
                 is_read:     req.is_read,
                 tx_byte:     req.tx_byte,
                 rx_byte:     req.rx_byte,
                 int_pending: req.int_pending,
                 ctrl_error:  req.ctrl_error};
    end
  end

  // step logic
  i2c_mrt_step #(
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES),
    .INDEX_BITS     (INDEX_BITS)
  ) u_step (
    .rq            (req_q),
    .st            (st),
    .data_pos      (data_pos),
    .st_next       (st_next),
    .data_pos_next (data_pos_next),
    .ctl           (ctl_next),
    .store_index   (store_index_next),
    .next_index    (next_index_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      data_pos <= '0;
    end else if (adv) begin
      st       <= st_next;
      data_pos <= data_pos_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl         <= ctl_next;
      store_index <= store_index_next;
      next_index  <= next_index_next;
    end
  end

  assign res.valid        = res_vld;
  assign res.command      = ctl.command;
  assign res.slave_set    = ctl.slave_set;
  assign res.slave_read   = ctl.slave_read;
  assign res.slave_out    = ctl.slave_out;
  assign res.put_valid    = ctl.put_valid;
  assign res.put_byte     = ctl.put_byte;
  assign res.store_valid  = ctl.store_valid;
  assign res.store_index  = store_index;
  assign res.store_byte   = ctl.store_byte;
  assign res.next_index   = next_index;
  assign res.done_res     = ctl.done_res;
  assign res.result_error = ctl.result_error;

endmodule

/* hw/rtl/i2c_mrt_step.sv */
// ----------------------------------------------------------------------------
// I2C master register transfer: step logic
// Next state and result for one registered request against the current state.
// ----------------------------------------------------------------------------
module i2c_mrt_step
  import i2c_mrt_pkg::*;
#(
  parameter int MAX_ADDR_BYTES = 4,
  parameter int INDEX_BITS     = 16
) (
  input  req_t                  rq,
  input  state_t                st,
  input  logic [INDEX_BITS-1:0] data_pos,
  output state_t                st_next,
  output logic [INDEX_BITS-1:0] data_pos_next,
  output ctl_t                  ctl,
  output logic [INDEX_BITS-1:0] store_index,
  output logic [INDEX_BITS-1:0] next_index
);

  // compare width wide enough for the position plus one and the size
  localparam int CW = ((INDEX_BITS > 16) ? INDEX_BITS : 16) + 1;

  logic [2:0]            len;
  logic [INDEX_BITS-1:0] pos_inc;
  logic [CW-1:0]         pos_ext;
  logic [CW-1:0]         size_ext;
  logic                  do_data;

  // clamp the address length
  always_comb begin
    if (rq.addr_len > 4'(MAX_ADDR_BYTES)) begin
      len = 3'(MAX_ADDR_BYTES);
    end else begin
      len = rq.addr_len[2:0];
    end
  end

  assign pos_inc  = data_pos + INDEX_BITS'(1);
  assign pos_ext  = CW'(pos_inc);
  assign size_ext = CW'(st.size_hold);

  // sequencer
  always_comb begin
    st_next       = st;
    data_pos_next = data_pos;
    ctl           = '0;
    store_index   = '0;
    do_data       = 1'b0;

    if (rq.req_type == REQ_START) begin
      if (st.phase == PH_IDLE) begin
        if (rq.addr_len == 4'd0 || rq.data_size == 16'd0) begin
          ctl.done_res = 1'b1;
        end else begin
          st_next.slave_hold    = rq.slave_addr;
          st_next.address_hold  = rq.mem_addr;
          st_next.address_count = len;
          st_next.read_mode     = rq.is_read;
          st_next.size_hold     = rq.data_size;
          st_next.address_pos   = 3'd1;
          st_next.phase         = PH_ADDR;
          data_pos_next         = '0;
          ctl.slave_set         = 1'b1;
          ctl.slave_out         = rq.slave_addr;
          ctl.put_valid         = 1'b1;
          ctl.put_byte          = addr_byte(rq.mem_addr, len, 3'd0);
          ctl.command           = CMD_SEND_START;
        end
      end
    end else if (st.phase != PH_IDLE) begin
      if (rq.ctrl_error != ERR_NONE) begin
        st_next.phase    = PH_IDLE;
        ctl.done_res     = 1'b1;
        ctl.result_error = rq.ctrl_error;
      end else if (rq.int_pending) begin
        case (st.phase)
          PH_ADDR: begin
            if (st.address_pos < st.address_count) begin
              ctl.put_valid       = 1'b1;
              ctl.put_byte        = addr_byte(st.address_hold, st.address_count,
                                              st.address_pos);
              st_next.address_pos = st.address_pos + 3'd1;
              ctl.command         = CMD_SEND_CONT;
            end else begin
              st_next.phase = PH_DATA;
              if (st.read_mode) begin
                // repeated start with read
                ctl.slave_set  = 1'b1;
                ctl.slave_read = 1'b1;
                ctl.slave_out  = st.slave_hold;
                if (st.size_hold == 16'd1) begin
                  st_next.phase = PH_FINISH;
                  ctl.command   = CMD_SINGLE_RECV;
                end else begin
                  ctl.command = CMD_RECV_START;
                end
              end else begin
                do_data = 1'b1;
              end
            end
          end
          PH_DATA: begin
            do_data = 1'b1;
          end
          default: begin
            // last event of the transfer
            if (st.read_mode) begin
              ctl.store_valid = 1'b1;
              store_index     = data_pos;
              ctl.store_byte  = rq.rx_byte;
            end
            st_next.phase = PH_IDLE;
            ctl.done_res  = 1'b1;
          end
        endcase

        if (do_data) begin
          data_pos_next = pos_inc;
          if (st.read_mode) begin
            ctl.store_valid = 1'b1;
            store_index     = data_pos;
            ctl.store_byte  = rq.rx_byte;
            if (pos_ext + CW'(1) < size_ext) begin
              ctl.command = CMD_RECV_CONT;
            end else begin
              st_next.phase = PH_FINISH;
              ctl.command   = CMD_RECV_FINISH;
            end
          end else begin
            ctl.put_valid = 1'b1;
            ctl.put_byte  = rq.tx_byte;
            if (pos_ext < size_ext) begin
              ctl.command = CMD_SEND_CONT;
            end else begin
              st_next.phase = PH_FINISH;
              ctl.command   = CMD_SEND_FINISH;
            end
          end
        end
      end
    end

    next_index = (st_next.phase != PH_IDLE) ? data_pos_next : '0;
  end

endmodule

/* hw/rtl/i2c_mrt_checker.sv */
// ----------------------------------------------------------------------------
// I2C master register transfer: port checker
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module i2c_mrt_checker
  import i2c_mrt_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [2:0]            command,
  input logic                  slave_set,
  input logic                  put_valid,
  input logic                  store_valid,
  input logic                  done_res,
  input logic [1:0]            result_error,
  input logic [INDEX_BITS-1:0] next_index
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(command) && $stable(done_res))
    else $error("result changed while stalled");

  // one step never both puts and stores a byte
  a_put_store: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(put_valid && store_valid))
    else $error("put and store in one step");

  // an error end carries no command and no byte
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && result_error != ERR_NONE |->
      done_res && command == CMD_NONE && !put_valid && !store_valid)
    else $error("error result carries a command or byte");

  // slave address is loaded only with a start-type command
  a_slave_cmd: assert property (@(posedge clk) disable iff (rst)
    res_valid && slave_set |->
      command == CMD_SEND_START || command == CMD_SINGLE_RECV ||
      command == CMD_RECV_START)
    else $error("slave load without start command");

  // an ended transfer reports index zero
  a_done_idx: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> next_index == '0)
    else $error("next index nonzero at end");

endmodule

bind i2c_master_register_transfer i2c_mrt_checker #(.INDEX_BITS(INDEX_BITS)) u_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .command      (res.command),
  .slave_set    (res.slave_set),
  .put_valid    (res.put_valid),
  .store_valid  (res.store_valid),
  .done_res     (res.done_res),
  .result_error (res.result_error),
  .next_index   (res.next_index)
);
